@@ rtl/arm_next_pc_predictor_defines.svh @@
`ifndef ARM_NEXT_PC_PREDICTOR_DEFINES_SVH
`define ARM_NEXT_PC_PREDICTOR_DEFINES_SVH

// Concurrent checks sampled on i_clk, muted while i_rst_n is low.

`define NPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define NPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/arm_npc_pkg.sv @@
package arm_npc_pkg;

    localparam int REG_W       = 32;
    localparam int NUM_CORE    = 16;
    localparam int REG_IDX_W   = $clog2(NUM_CORE);
    localparam int ID_W        = 5;
    localparam int FUNC_W      = 2;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 72;

    localparam logic [ID_W-1:0]      ID_STATUS = 5'd25;
    localparam logic [REG_IDX_W-1:0] IDX_PC    = 4'd15;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE   = 2'd0,
        FN_READ    = 2'd1,
        FN_PREDICT = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
        CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
        CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
        CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
    } t_cond;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [REG_W-1:0] instr;
        logic [REG_W-1:0] write_data;
        logic [ID_W-1:0]  reg_id;
        t_func            func;
    } t_req;

    typedef struct packed {
        logic             load_needed;
        logic [REG_W-1:0] next_addr;
        logic             ok;
        logic [REG_W-1:0] read_data;
    } t_res;

endpackage

@@ rtl/arm_next_pc_predictor.sv @@
// A request is accepted in the idle state and its register file RAM read is registered;
// its result is computed in the execute state and registered into the output register once
// that register is free or being drained. A new request is accepted only after the previous
// one has retired, so requests do not overlap.
// Reset (i_rst_n low, synchronous) clears the FSM, output valid, status word and the
// per-register valid bits, so all registers read as zero until written.
`include "arm_next_pc_predictor_defines.svh"

module arm_next_pc_predictor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] func, [6:2] reg_id, [38:7] write_data, [70:39] instr, [71] zero
    input  logic [arm_npc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] read_data, [32] ok, [64:33] next_addr, [71:65] zero
    output logic [arm_npc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] load_needed
    output logic                                m_axis_tuser
);

    localparam int IW = arm_npc_pkg::REG_IDX_W;

    arm_npc_pkg::t_state              r_state, n_state;
    arm_npc_pkg::t_req                r_req, in_req;
    arm_npc_pkg::t_res                r_out, exec_res;
    logic                             r_out_vld;
    logic [arm_npc_pkg::NUM_CORE-1:0] r_vld;
    logic                             r_vld_a, r_vld_pc;
    logic [arm_npc_pkg::REG_W-1:0]    r_status;
    logic [IW-1:0]                    r_addr_a;

    logic                             s_acc;
    logic                             commit;
    logic [IW-1:0]                    in_addr_a, rd_addr_a;
    logic [arm_npc_pkg::REG_W-1:0]    q_a, q_pc, reg_a, reg_pc;
    logic                             wr_core;

    assign in_req = arm_npc_pkg::t_req'(s_axis_tdata[70:0]);
    assign s_acc  = s_axis_tvalid && s_axis_tready;

    // Port A address: the register id for read/write, Rn for a block load, Rm otherwise.
    always_comb begin
        if (in_req.func == arm_npc_pkg::FN_PREDICT) begin
            in_addr_a = in_req.instr[27] ? in_req.instr[19:16] : in_req.instr[3:0];
        end else begin
            in_addr_a = in_req.reg_id[IW-1:0];
        end
    end

    // Hold the address of the request in flight so a stalled result keeps its read data.
    assign rd_addr_a = (r_state == arm_npc_pkg::ST_IDLE) ? in_addr_a : r_addr_a;

    // Core registers: two copies written together, one read port each.
    arm_npc_ram #(
        .WIDTH (arm_npc_pkg::REG_W),
        .DEPTH (arm_npc_pkg::NUM_CORE)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_core),
        .i_waddr (r_req.reg_id[IW-1:0]),
        .i_wdata (r_req.write_data),
        .i_raddr (rd_addr_a),
        .o_rdata (q_a)
    );

    arm_npc_ram #(
        .WIDTH (arm_npc_pkg::REG_W),
        .DEPTH (arm_npc_pkg::NUM_CORE)
    ) u_ram_pc (
        .i_clk   (i_clk),
        .i_we    (wr_core),
        .i_waddr (r_req.reg_id[IW-1:0]),
        .i_wdata (r_req.write_data),
        .i_raddr (arm_npc_pkg::IDX_PC),
        .o_rdata (q_pc)
    );

    // Never-written entries read as their reset value of zero.
    assign reg_a  = r_vld_a  ? q_a  : '0;
    assign reg_pc = r_vld_pc ? q_pc : '0;

    arm_npc_exec u_exec (
        .i_req    (r_req),
        .i_reg_a  (reg_a),
        .i_pc     (reg_pc),
        .i_status (r_status),
        .o_res    (exec_res)
    );

    // Retire the request once the output register is free or being drained.
    always_comb begin
        n_state       = r_state;
        commit        = 1'b0;
        s_axis_tready = 1'b0;
        case (r_state)
            arm_npc_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = arm_npc_pkg::ST_EXEC;
                end
            end
            arm_npc_pkg::ST_EXEC: begin
                if (!r_out_vld || m_axis_tready) begin
                    commit  = 1'b1;
                    n_state = arm_npc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arm_npc_pkg::ST_IDLE;
            end
        endcase
    end

    assign wr_core = commit && (r_req.func == arm_npc_pkg::FN_WRITE) && !r_req.reg_id[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arm_npc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request and the valid bits of the entries being read.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_req    <= in_req;
            r_addr_a <= in_addr_a;
            r_vld_a  <= r_vld[in_addr_a];
            r_vld_pc <= r_vld[arm_npc_pkg::IDX_PC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_status <= '0;
        end else if (commit && (r_req.func == arm_npc_pkg::FN_WRITE)) begin
            if (!r_req.reg_id[4]) begin
                r_vld[r_req.reg_id[IW-1:0]] <= 1'b1;
            end else if (r_req.reg_id == arm_npc_pkg::ID_STATUS) begin
                r_status <= r_req.write_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (commit) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= exec_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out.next_addr, r_out.ok, r_out.read_data};
    assign m_axis_tuser  = r_out.load_needed;

    `NPC_ASSERT_NEXT(a_acc_to_exec, s_acc, r_state == arm_npc_pkg::ST_EXEC,
        "accepted request did not enter execute")
    `NPC_ASSERT_IMP(a_out_from_exec, $rose(r_out_vld),
        $past(r_state) == arm_npc_pkg::ST_EXEC, "result appeared without execute")
    `NPC_ASSERT_IMP(a_load_ok, r_out_vld && r_out.load_needed, r_out.ok,
        "load flag set on a failed result")
    `NPC_ASSERT_NEXT(a_wr_sets_valid, wr_core, r_vld[$past(r_req.reg_id[IW-1:0])],
        "core register write left entry invalid")

endmodule

@@ rtl/arm_npc_ram.sv @@
module arm_npc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/arm_npc_exec.sv @@
module arm_npc_exec (
    input  arm_npc_pkg::t_req                i_req,
    input  logic [arm_npc_pkg::REG_W-1:0]    i_reg_a,
    input  logic [arm_npc_pkg::REG_W-1:0]    i_pc,
    input  logic [arm_npc_pkg::REG_W-1:0]    i_status,
    output arm_npc_pkg::t_res                o_res
);

    logic                              n_flag, z_flag, c_flag, v_flag;
    logic                              cond_ok;
    logic [arm_npc_pkg::REG_W-1:0]     ins;
    logic [arm_npc_pkg::REG_W-1:0]     pc_plus4;
    logic [arm_npc_pkg::REG_W-1:0]     br_off;
    logic                              is_branch, is_mov, is_ldm;
    logic [3:0]                        cnt;
    logic [5:0]                        cnt_x4;
    logic [arm_npc_pkg::REG_W-1:0]     ldm_addr;
    logic [arm_npc_pkg::REG_W-1:0]     pred_addr;
    logic                              pred_load;

    assign ins    = i_req.instr;
    assign n_flag = i_status[31];
    assign z_flag = i_status[30];
    assign c_flag = i_status[29];
    assign v_flag = i_status[28];

    always_comb begin
        case (arm_npc_pkg::t_cond'(ins[31:28]))
            arm_npc_pkg::CC_EQ: cond_ok = z_flag;
            arm_npc_pkg::CC_NE: cond_ok = !z_flag;
            arm_npc_pkg::CC_CS: cond_ok = c_flag;
            arm_npc_pkg::CC_CC: cond_ok = !c_flag;
            arm_npc_pkg::CC_MI: cond_ok = n_flag;
            arm_npc_pkg::CC_PL: cond_ok = !n_flag;
            arm_npc_pkg::CC_VS: cond_ok = v_flag;
            arm_npc_pkg::CC_VC: cond_ok = !v_flag;
            arm_npc_pkg::CC_HI: cond_ok = c_flag && !z_flag;
            arm_npc_pkg::CC_LS: cond_ok = !c_flag || z_flag;
            arm_npc_pkg::CC_GE: cond_ok = (n_flag == v_flag);
            arm_npc_pkg::CC_LT: cond_ok = (n_flag != v_flag);
            arm_npc_pkg::CC_GT: cond_ok = !z_flag && (n_flag == v_flag);
            arm_npc_pkg::CC_LE: cond_ok = z_flag || (n_flag != v_flag);
            arm_npc_pkg::CC_AL: cond_ok = 1'b1;
            default:            cond_ok = 1'b0;
        endcase
    end

    // Count the register list below pc, one bit per register.
    always_comb begin
        cnt = 4'd0;
        for (int i = 0; i < 15; i++) begin
            cnt = cnt + {3'd0, ins[i]};
        end
    end

    assign cnt_x4   = {cnt, 2'b00};
    assign pc_plus4 = i_pc + 32'd4;
    assign br_off   = {{6{ins[23]}}, ins[23:0], 2'b00};

    assign is_branch = (ins[27:25] == 3'b101);
    assign is_mov    = ((ins & 32'h0fa0_0000) == 32'h01a0_0000) && (ins[15:12] == 4'hf);
    assign is_ldm    = ins[27] && ins[20] && ins[15];

    // Bit 23 selects increment, bit 24 selects the "before" variants.
    always_comb begin
        if (ins[23]) begin
            ldm_addr = i_reg_a + {26'd0, cnt_x4} + (ins[24] ? 32'd4 : 32'd0);
        end else begin
            ldm_addr = ins[24] ? (i_reg_a - 32'd4) : i_reg_a;
        end
    end

    always_comb begin
        pred_load = 1'b0;
        if (!cond_ok) begin
            pred_addr = pc_plus4;
        end else if (is_branch) begin
            pred_addr = i_pc + 32'd8 + br_off;
        end else if (is_mov) begin
            pred_addr = i_reg_a;
        end else if (is_ldm) begin
            pred_addr = ldm_addr;
            pred_load = 1'b1;
        end else begin
            pred_addr = pc_plus4;
        end
    end

    always_comb begin
        o_res = '0;
        case (i_req.func)
            arm_npc_pkg::FN_WRITE: begin
                o_res.ok = (i_req.reg_id <= arm_npc_pkg::ID_STATUS);
            end
            arm_npc_pkg::FN_READ: begin
                if (i_req.reg_id[4] == 1'b0) begin
                    o_res.ok        = 1'b1;
                    o_res.read_data = i_reg_a;
                end else if (i_req.reg_id == arm_npc_pkg::ID_STATUS) begin
                    o_res.ok        = 1'b1;
                    o_res.read_data = i_status;
                end
            end
            arm_npc_pkg::FN_PREDICT: begin
                o_res.ok          = 1'b1;
                o_res.next_addr   = pred_addr;
                o_res.load_needed = pred_load;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule
